/* src/sn2d_pkg.sv */
// shared constants and lookup functions for the 2d simplex noise pipeline
package sn2d_pkg;

    // skew factor (sqrt3-1)/2 in q0.20, unskew factor (3-sqrt3)/6 in q0.16
    localparam logic signed [19:0] F2_Q20 = 20'sd383805;
    localparam logic [13:0]        G2_Q16 = 14'd13849;

    // offset and corner term widths
    localparam int DW = 18;
    localparam int TERM_W = 50;

    // permutation table
    localparam logic [7:0] PERM [256] = '{
        8'h97, 8'ha0, 8'h89, 8'h5b, 8'h5a, 8'h0f, 8'h83, 8'h0d,
        8'hc9, 8'h5f, 8'h60, 8'h35, 8'hc2, 8'he9, 8'h07, 8'he1,
        8'h8c, 8'h24, 8'h67, 8'h1e, 8'h45, 8'h8e, 8'h08, 8'h63,
        8'h25, 8'hf0, 8'h15, 8'h0a, 8'h17, 8'hbe, 8'h06, 8'h94,
        8'hf7, 8'h78, 8'hea, 8'h4b, 8'h00, 8'h1a, 8'hc5, 8'h3e,
        8'h5e, 8'hfc, 8'hdb, 8'hcb, 8'h75, 8'h23, 8'h0b, 8'h20,
        8'h39, 8'hb1, 8'h21, 8'h58, 8'hed, 8'h95, 8'h38, 8'h57,
        8'hae, 8'h14, 8'h7d, 8'h88, 8'hab, 8'ha8, 8'h44, 8'haf,
        8'h4a, 8'ha5, 8'h47, 8'h86, 8'h8b, 8'h30, 8'h1b, 8'ha6,
        8'h4d, 8'h92, 8'h9e, 8'he7, 8'h53, 8'h6f, 8'he5, 8'h7a,
        8'h3c, 8'hd3, 8'h85, 8'he6, 8'hdc, 8'h69, 8'h5c, 8'h29,
        8'h37, 8'h2e, 8'hf5, 8'h28, 8'hf4, 8'h66, 8'h8f, 8'h36,
        8'h41, 8'h19, 8'h3f, 8'ha1, 8'h01, 8'hd8, 8'h50, 8'h49,
        8'hd1, 8'h4c, 8'h84, 8'hbb, 8'hd0, 8'h59, 8'h12, 8'ha9,
        8'hc8, 8'hc4, 8'h87, 8'h82, 8'h74, 8'hbc, 8'h9f, 8'h56,
        8'ha4, 8'h64, 8'h6d, 8'hc6, 8'had, 8'hba, 8'h03, 8'h40,
        8'h34, 8'hd9, 8'he2, 8'hfa, 8'h7c, 8'h7b, 8'h05, 8'hca,
        8'h26, 8'h93, 8'h76, 8'h7e, 8'hff, 8'h52, 8'h55, 8'hd4,
        8'hcf, 8'hce, 8'h3b, 8'he3, 8'h2f, 8'h10, 8'h3a, 8'h11,
        8'hb6, 8'hbd, 8'h1c, 8'h2a, 8'hdf, 8'hb7, 8'haa, 8'hd5,
        8'h77, 8'hf8, 8'h98, 8'h02, 8'h2c, 8'h9a, 8'ha3, 8'h46,
        8'hdd, 8'h99, 8'h65, 8'h9b, 8'ha7, 8'h2b, 8'hac, 8'h09,
        8'h81, 8'h16, 8'h27, 8'hfd, 8'h13, 8'h62, 8'h6c, 8'h6e,
        8'h4f, 8'h71, 8'he0, 8'he8, 8'hb2, 8'hb9, 8'h70, 8'h68,
        8'hda, 8'hf6, 8'h61, 8'he4, 8'hfb, 8'h22, 8'hf2, 8'hc1,
        8'hee, 8'hd2, 8'h90, 8'h0c, 8'hbf, 8'hb3, 8'ha2, 8'hf1,
        8'h51, 8'h33, 8'h91, 8'heb, 8'hf9, 8'h0e, 8'hef, 8'h6b,
        8'h31, 8'hc0, 8'hd6, 8'h1f, 8'hb5, 8'hc7, 8'h6a, 8'h9d,
        8'hb8, 8'h54, 8'hcc, 8'hb0, 8'h73, 8'h79, 8'h32, 8'h2d,
        8'h7f, 8'h04, 8'h96, 8'hfe, 8'h8a, 8'hec, 8'hcd, 8'h5d,
        8'hde, 8'h72, 8'h43, 8'h1d, 8'h18, 8'h48, 8'hf3, 8'h8d,
        8'h80, 8'hc3, 8'h4e, 8'h42, 8'hd7, 8'h3d, 8'h9c, 8'hb4
    };

    function automatic logic [7:0] perm_lut(input logic [7:0] a);
        return PERM[a];
    endfunction

    // h mod 12 via reciprocal multiply, exact for all 8-bit h
    function automatic logic [3:0] mod12(input logic [7:0] h);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = {8'd0, h} * 16'd171;
        q = p[15:11];
        r = h - {q, 3'b000} - {1'b0, q, 2'b00};
        return r[3:0];
    endfunction

endpackage

/* src/simplex_noise_2d.sv */
// 2d simplex noise pipeline: one point in, one q2.16 noise value out
// throughput: one point per cycle; the pipeline holds as a whole while the
// output item is stalled
// reset clears only the stage valid bits; payload registers are not reset
module simplex_noise_2d #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [39:0] i_point_x,
    input  logic signed [39:0] i_point_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_noise_value
);

    localparam int FB = COORD_FRAC_BITS;
    localparam int LW = FB + 8;
    localparam int DW = sn2d_pkg::DW;
    localparam int TW = sn2d_pkg::TERM_W;
    localparam int NST = 11;

    logic en;
    logic [NST-1:0] r_vld;

    // stage 1: coordinate sum
    logic signed [40:0]  r1_sum;
    logic [LW-1:0]       r1_xl, r1_yl;
    // stage 2: skew
    logic signed [60:0]  prod_s;
    logic [LW-1:0]       r2_s, r2_xl, r2_yl;
    // stage 3: cell and fraction
    logic [LW-1:0]       xs, ys;
    logic [15:0]         fx16, fy16;
    logic [7:0]          r3_ci, r3_cj;
    logic [15:0]         r3_fx, r3_fy;
    // stage 4: unskew
    logic [16:0]         fsum;
    logic [31:0]         tp;
    logic signed [DW-1:0] n4_x0, n4_y0;
    logic signed [DW-1:0] r4_x0, r4_y0;
    logic [7:0]          r4_ci, r4_pj0, r4_pj1;
    // stage 5: corner offsets and gradient indices
    logic                i1;
    logic signed [DW-1:0] r5_x0, r5_y0, r5_x1, r5_y1, r5_x2, r5_y2;
    logic [3:0]          r5_g0, r5_g1, r5_g2;
    logic [7:0]          a1, b1;
    // corner terms and final sum
    logic signed [TW-1:0] term0, term1, term2;
    logic signed [TW+1:0] r10_sum;
    logic signed [TW+8:0] scaled;
    logic signed [TW-24:0] rnd;
    logic signed [17:0]   r_out;

    // whole-pipeline advance unless the output item is held
    assign en      = ~(r_vld[NST-1] & i_stall);
    assign o_stall = r_vld[NST-1] & i_stall;
    assign o_valid = r_vld[NST-1];
    assign o_noise_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // skew product, low bits of the floored shift
    assign prod_s = r1_sum * sn2d_pkg::F2_Q20;

    // skewed coordinates, only cell and fraction bits needed
    assign xs = r2_xl + r2_s;
    assign ys = r2_yl + r2_s;

    generate
        if (FB >= 16) begin : g_frac_shr
            assign fx16 = xs[FB-1:FB-16];
            assign fy16 = ys[FB-1:FB-16];
        end else begin : g_frac_shl
            assign fx16 = {xs[FB-1:0], {(16-FB){1'b0}}};
            assign fy16 = ys[FB-1:0] << (16 - FB);
        end
    endgenerate

    // unskew with rounded (fx+fy)*g2
    always_comb begin
        fsum  = {1'b0, r3_fx} + {1'b0, r3_fy};
        tp    = {15'd0, fsum} * {18'd0, sn2d_pkg::G2_Q16} + 32'd32768;
        n4_x0 = $signed({2'b00, r3_fx}) - $signed({2'b00, tp[31:16]});
        n4_y0 = $signed({2'b00, r3_fy}) - $signed({2'b00, tp[31:16]});
    end

    // middle corner choice and hashed lattice coordinates
    always_comb begin
        i1 = (r4_x0 > r4_y0);
        a1 = r4_ci + {7'd0, i1};
        b1 = i1 ? r4_pj0 : r4_pj1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sum <= 41'(i_point_x) + 41'(i_point_y);
            r1_xl  <= i_point_x[LW-1:0];
            r1_yl  <= i_point_y[LW-1:0];

            r2_s   <= prod_s[20+LW-1:20];
            r2_xl  <= r1_xl;
            r2_yl  <= r1_yl;

            r3_ci  <= xs[LW-1:FB];
            r3_cj  <= ys[LW-1:FB];
            r3_fx  <= fx16;
            r3_fy  <= fy16;

            r4_x0  <= n4_x0;
            r4_y0  <= n4_y0;
            r4_ci  <= r3_ci;
            r4_pj0 <= sn2d_pkg::perm_lut(r3_cj);
            r4_pj1 <= sn2d_pkg::perm_lut(r3_cj + 8'd1);

            r5_x0  <= r4_x0;
            r5_y0  <= r4_y0;
            r5_x1  <= r4_x0 - (i1 ? 18'sd65536 : 18'sd0) + 18'sd13849;
            r5_y1  <= r4_y0 - (i1 ? 18'sd0 : 18'sd65536) + 18'sd13849;
            r5_x2  <= r4_x0 - 18'sd37838;
            r5_y2  <= r4_y0 - 18'sd37838;
            r5_g0  <= sn2d_pkg::mod12(sn2d_pkg::perm_lut(r4_ci + r4_pj0));
            r5_g1  <= sn2d_pkg::mod12(sn2d_pkg::perm_lut(a1 + b1));
            r5_g2  <= sn2d_pkg::mod12(sn2d_pkg::perm_lut(r4_ci + 8'd1 + r4_pj1));
        end
    end

    // three corner units
    sn2d_corner u_corner0 (
        .i_clk(i_clk), .i_en(en), .i_dx(r5_x0), .i_dy(r5_y0), .i_grad(r5_g0),
        .o_term(term0)
    );
    sn2d_corner u_corner1 (
        .i_clk(i_clk), .i_en(en), .i_dx(r5_x1), .i_dy(r5_y1), .i_grad(r5_g1),
        .o_term(term1)
    );
    sn2d_corner u_corner2 (
        .i_clk(i_clk), .i_en(en), .i_dx(r5_x2), .i_dy(r5_y2), .i_grad(r5_g2),
        .o_term(term2)
    );

    // scale by 70, round half up to q.16
    assign scaled = (TW+9)'(r10_sum) * (TW+9)'(70) + (TW+9)'(64'sd2147483648);
    assign rnd    = scaled[TW+8:32];

    // sum of terms, then scaled and saturated result
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_sum <= (TW+2)'(term0) + (TW+2)'(term1) + (TW+2)'(term2);
            if (rnd < -(TW-23)'(131072)) begin
                r_out <= -18'sd131072;
            end else if (rnd > (TW-23)'(131071)) begin
                r_out <= 18'sd131071;
            end else begin
                r_out <= rnd[17:0];
            end
        end
    end

endmodule

/* src/sn2d_corner.sv */
// one simplex corner: falloff, fourth power and gradient dot product
module sn2d_corner (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [sn2d_pkg::DW-1:0]    i_dx,
    input  logic signed [sn2d_pkg::DW-1:0]    i_dy,
    input  logic [3:0]                        i_grad,
    output logic signed [sn2d_pkg::TERM_W-1:0] o_term
);

    localparam int DW = sn2d_pkg::DW;
    localparam int TW = sn2d_pkg::TERM_W;

    logic signed [2*DW-1:0] sqx, sqy;
    logic signed [37:0]     n_t;
    logic signed [DW:0]     n_dot;
    logic signed [DW:0]     dxe, dye;
    logic signed [37:0]     r_t;
    logic signed [DW:0]     r_dot1, r_dot2, r_dot3;
    logic [15:0]            th;
    logic [31:0]            t2;
    logic [14:0]            r_t2h;
    logic                   r_neg2, r_neg3;
    logic [29:0]            t4;
    logic [29:0]            r_t4;
    logic signed [TW-1:0]   prod;
    logic signed [TW-1:0]   r_term;

    // squared distance and falloff, gradient dot product
    always_comb begin
        sqx = i_dx * i_dx;
        sqy = i_dy * i_dy;
        n_t = 38'sh80000000 - 38'(sqx) - 38'(sqy);
        dxe = (DW+1)'(i_dx);
        dye = (DW+1)'(i_dy);
        case (i_grad)
            4'd0:    n_dot = dxe + dye;
            4'd1:    n_dot = dye - dxe;
            4'd2:    n_dot = dxe - dye;
            4'd3:    n_dot = -dxe - dye;
            4'd4:    n_dot = dxe;
            4'd5:    n_dot = -dxe;
            4'd6:    n_dot = dxe;
            4'd7:    n_dot = -dxe;
            4'd8:    n_dot = dye;
            4'd9:    n_dot = -dye;
            4'd10:   n_dot = dye;
            4'd11:   n_dot = -dye;
            default: n_dot = '0;
        endcase
    end

    assign th = r_t[31:16];
    assign t2 = {16'd0, th} * {16'd0, th};
    assign t4 = {15'd0, r_t2h} * {15'd0, r_t2h};
    assign prod = $signed({1'b0, r_t4}) * r_dot3;

    // falloff squared, then fourth power, then weighted term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= n_t;
            r_dot1 <= n_dot;
            r_t2h  <= t2[30:16];
            r_neg2 <= r_t[37];
            r_dot2 <= r_dot1;
            r_t4   <= t4;
            r_neg3 <= r_neg2;
            r_dot3 <= r_dot2;
            r_term <= r_neg3 ? '0 : prod;
        end
    end

    assign o_term = r_term;

endmodule

/* test/simplex_noise_2d_test.sv */
// self-checking testbench for the 2d simplex noise pipeline
module simplex_noise_2d_test;

    // clock, reset and block ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [39:0] i_point_x = '0;
    logic signed [39:0] i_point_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [17:0] o_noise_value;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    // gradient set
    localparam int GRAD_X [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
    localparam int GRAD_Y [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};

    logic signed [17:0] noise_expected [$];
    int  error_count = 0;
    int  idle_count = 0;
    bit  calm = 1'b0;

    simplex_noise_2d dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor division by a power of two
    function automatic longint floor_div2(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic int gradient_of(input int a, input int b);
        int h;
        h = sn2d_pkg::PERM[(a + sn2d_pkg::PERM[b & 255]) & 255];
        return h % 12;
    endfunction

    // one corner term in q.48
    function automatic longint corner_term(input longint dx, input longint dy, input int g);
        longint t, t2, t4, dot;
        t = (longint'(1) <<< 31) - dx * dx - dy * dy;
        if (t < 0) return 0;
        t2 = (t >>> 16) * (t >>> 16);
        t4 = (t2 >>> 16) * (t2 >>> 16);
        dot = GRAD_X[g] * dx + GRAD_Y[g] * dy;
        return t4 * dot;
    endfunction

    // expected noise for one point
    function automatic logic signed [17:0] noise_at(input logic signed [39:0] px,
                                                    input logic signed [39:0] py);
        longint x, y, s, xs, ys, fx, fy, t, x0, y0, x1, y1, x2, y2, sum, r;
        int ci, cj, i1, j1;
        x = px;
        y = py;
        s = floor_div2((x + y) * 383805, 20);
        xs = x + s;
        ys = y + s;
        ci = int'((xs >>> 16) & 255);
        cj = int'((ys >>> 16) & 255);
        fx = xs & 64'hffff;
        fy = ys & 64'hffff;
        t = ((fx + fy) * 13849 + 32768) >>> 16;
        x0 = fx - t;
        y0 = fy - t;
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        x1 = x0 - i1 * 65536 + 13849;
        y1 = y0 - j1 * 65536 + 13849;
        x2 = x0 - 65536 + 2 * 13849;
        y2 = y0 - 65536 + 2 * 13849;
        sum = corner_term(x0, y0, gradient_of(ci, cj));
        sum += corner_term(x1, y1, gradient_of(ci + i1, cj + j1));
        sum += corner_term(x2, y2, gradient_of(ci + 1, cj + 1));
        r = floor_div2(sum * 70 + (longint'(1) <<< 31), 32);
        if (r < -131072) r = -131072;
        if (r > 131071) r = 131071;
        return r[17:0];
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 22);
    endfunction

    // send one point, with random gaps before it
    task automatic send_point(input logic signed [39:0] px, input logic signed [39:0] py);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        noise_expected.push_back(noise_at(px, py));
    endtask

    // receiver stall
    always @(posedge i_clk) i_stall <= idle_now();

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (noise_expected.size() == 0) begin
                $display("%0t: unexpected result %0d", $time, o_noise_value);
                error_count++;
            end else begin
                if (o_noise_value !== noise_expected[0]) begin
                    $display("%0t: noise_value expected %0d actual %0d",
                             $time, noise_expected[0], o_noise_value);
                    error_count++;
                end
                void'(noise_expected.pop_front());
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_count = 0;
        else idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("simplex_noise_2d regression: fail");
            $finish;
        end
    end

    function automatic logic signed [39:0] rand40();
        return 40'({$urandom, $urandom});
    endfunction

    // extremes of the coordinate range and the sign changes
    task automatic test_extremes();
        logic signed [39:0] v [6];
        v = '{40'sh8000000000, 40'sh7fffffffff, 40'sd0, -40'sd1, 40'sd1, 40'shffffffffff};
        foreach (v[a]) send_point(v[a], v[(a + 2) % 6]);
        send_point(40'sh8000000000, 40'sh8000000000);
        send_point(40'sh7fffffffff, 40'sh7fffffffff);
    endtask

    // negative coordinates near cell edges use a true floor
    task automatic test_negative_floor();
        send_point(-40'sd65536, -40'sd1);
        send_point(-40'sd1, -40'sd65537);
        send_point(-40'sd32768, 40'sd32768);
        send_point(-40'sd200000, -40'sd3);
    endtask

    // lattice wraps every 256 cells
    task automatic test_wrap();
        send_point(40'sd12345, 40'sd54321);
        send_point(40'sd12345 + (40'sd256 <<< 16), 40'sd54321 + (40'sd256 <<< 16));
        send_point(40'sd12345 - (40'sd256 <<< 16), 40'sd54321);
        send_point(40'sd65535, 40'sd65535);
        send_point(40'sd32768, 40'sd0);
        send_point(40'sd0, 40'sd32768);
    endtask

    // random points: some full range, some near the origin, some positive and shifted right
    task automatic test_random(input int n);
        logic signed [39:0] px, py;
        repeat (n) begin
            case ($urandom_range(3))
                0: begin
                    px = rand40();
                    py = rand40();
                end
                1: begin
                    px = $signed(40'($urandom_range(2097151))) - 40'sd1048576;
                    py = $signed(40'($urandom_range(2097151))) - 40'sd1048576;
                end
                default: begin
                    px = $signed(40'($urandom)) >>> $urandom_range(8);
                    py = $signed(40'($urandom)) >>> $urandom_range(8);
                end
            endcase
            send_point(px, py);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_negative_floor();
        test_wrap();
        test_random(500);
        // back-to-back stretch with no idling
        calm = 1'b1;
        test_random(250);
        calm = 1'b0;
        test_random(480);
        i_valid <= 1'b0;
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) $display("simplex_noise_2d regression: pass");
        else $display("simplex_noise_2d regression: fail");
        $finish;
    end

endmodule
